// ----- sv/plvf_pkg.sv -----
// ----------------------------------------------------------------------------
// plvf_pkg
// Shared types, constants and helpers for the Poisson leaf value fit block.
// ----------------------------------------------------------------------------
package plvf_pkg;

	localparam int MAX_LEAVES = 16;

	localparam logic [4:0]  LEAF_COUNT_RST   = 5'd16;
	localparam logic [15:0] PRESENT_MASK_RST = 16'hFFFF;

	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam logic [63:0] LN2_Q62 = 64'h2C5C_85FD_F473_DE6B;

	localparam logic signed [21:0] PRED_MAX = 22'sh1F_FFFF;
	localparam logic signed [21:0] PRED_MIN = 22'sh20_0000;

	localparam logic [4:0] TAYLOR_TERMS  = 5'd20;
	localparam logic [5:0] EXP_SQUARINGS = 6'd5;
	localparam logic [5:0] LOG_BITS      = 6'd40;

	typedef enum logic [0:0] {
		CFG_LEAF_COUNT   = 1'b0,
		CFG_PRESENT_MASK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0]  leaf_count;
		logic [15:0] present_mask;
	} cfg_t;

	// one classified observation on its way to the back end
	typedef struct packed {
		logic [23:0]        count_value;
		logic [23:0]        obs_weight;
		logic signed [20:0] x;
		logic [3:0]         leaf;
		logic               acc;
		logic               last;
	} work_t;

	function automatic logic [4:0] leaves_in_use(cfg_t c);
		return (c.leaf_count > 5'(MAX_LEAVES)) ? 5'(MAX_LEAVES) : c.leaf_count;
	endfunction

endpackage

// ----- sv/plvf_if.sv -----
// ----------------------------------------------------------------------------
// plvf_if
// Valid/ready channels for observations and leaf results.
// ----------------------------------------------------------------------------
interface plvf_obs_if;
	logic               valid;
	logic               ready;
	logic [23:0]        count_value;
	logic [23:0]        obs_weight;
	logic signed [20:0] score;
	logic signed [20:0] offset_term;
	logic               in_bag;
	logic [3:0]         leaf_index;
	logic               last_obs;

	modport source (output valid, count_value, obs_weight, score, offset_term, in_bag,
		leaf_index, last_obs, input ready);
	modport sink (input valid, count_value, obs_weight, score, offset_term, in_bag,
		leaf_index, last_obs, output ready);
endinterface

interface plvf_res_if;
	logic               valid;
	logic               ready;
	logic [3:0]         leaf_id;
	logic signed [21:0] prediction;
	logic               empty_leaf;
	logic               last_leaf;

	modport source (output valid, leaf_id, prediction, empty_leaf, last_leaf, input ready);
	modport sink (input valid, leaf_id, prediction, empty_leaf, last_leaf, output ready);
endinterface

// ----- sv/plvf_front.sv -----
// ----------------------------------------------------------------------------
// plvf_front
// Configuration registers, observation intake and classification.
// ----------------------------------------------------------------------------
module plvf_front
	import plvf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	plvf_obs_if.sink   obs,
	input  logic       cfg_we,
	input  cfg_reg_t   cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t       cfg,
	input  logic       full,
	output logic       push,
	output work_t      push_item
);

	cfg_t               cfg_q;
	logic signed [21:0] sum;
	logic signed [20:0] x_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leaf_count   <= LEAF_COUNT_RST;
			cfg_q.present_mask <= PRESENT_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEAF_COUNT:   cfg_q.leaf_count   <= cfg_data[4:0];
				CFG_PRESENT_MASK: cfg_q.present_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	// score + offset, clamped to [-16, 16)
	always_comb begin
		sum = {obs.score[20], obs.score} + {obs.offset_term[20], obs.offset_term};
		if (sum[21] != sum[20])
			x_sat = sum[21] ? 21'sh10_0000 : 21'sh0F_FFFF;
		else
			x_sat = sum[20:0];
	end

	always_comb begin
		push_item.count_value = obs.count_value;
		push_item.obs_weight  = obs.obs_weight;
		push_item.x           = x_sat;
		push_item.leaf        = obs.leaf_index;
		push_item.acc         = obs.in_bag && ({1'b0, obs.leaf_index} < leaves_in_use(cfg_q));
		push_item.last        = obs.last_obs;
	end

	assign obs.ready = !full;
	assign push      = obs.valid && !full;
	assign cfg       = cfg_q;

endmodule

// ----- sv/plvf_fifo.sv -----
// ----------------------------------------------------------------------------
// plvf_fifo
// Two-entry queue of classified observations between front and back end.
// ----------------------------------------------------------------------------
module plvf_fifo
	import plvf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output work_t head
);

	work_t      mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rptr_q];

endmodule

// ----- sv/plvf_mul.sv -----
// ----------------------------------------------------------------------------
// plvf_mul
// Q.62 fixed-point multiply, floor(a*b/2^62), from four 32x32 partial products.
// ----------------------------------------------------------------------------
module plvf_mul
	import plvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [1:0]   psh_s1;
	logic         ppv_s1;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  opa;
	logic [31:0]  opb;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		opa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		opb = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q && !cnt_q[2]) begin
			pp_s1  <= opa * opb;
			psh_s1 <= (cnt_q[1:0] == 2'd0) ? 2'd0 : ((cnt_q[1:0] == 2'd3) ? 2'd2 : 2'd1);
		end
		if (start)
			acc_q <= '0;
		else if (busy_q && ppv_s1)
			acc_q <= acc_q + ({64'd0, pp_s1} << {psh_s1, 5'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			ppv_s1 <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
			ppv_s1 <= 1'b0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 3'd1;
			ppv_s1 <= !cnt_q[2];
			if (cnt_q[2]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign p    = acc_q[125:62];

endmodule

// ----- sv/plvf_back.sv -----
// ----------------------------------------------------------------------------
// plvf_back
// Sequencer: exponential, per-leaf accumulation and log-ratio emission.
// ----------------------------------------------------------------------------
module plvf_back
	import plvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        empty,
	input  work_t       head,
	output logic        pop,
	plvf_res_if.source  res
);

	typedef enum logic [4:0] {
		S_IDLE, S_EXP_INIT, S_TERM_MUL, S_TERM_DIV, S_NORM, S_SQ, S_ROUND,
		S_WEH, S_WEL, S_WY, S_CONTRIB, S_RMW,
		S_EMIT_RD, S_EMIT_CHECK, S_LOG_NORM, S_LOG_SQ, S_LN_MUL, S_OUT
	} state_t;

	state_t state_q;
	work_t  item_q;

	// exponential datapath
	logic [4:0]         k_q;
	logic               neg_q;
	logic [63:0]        a_q;
	logic [63:0]        t_q;
	logic [63:0]        s_q;
	logic [63:0]        m_q;
	logic signed [11:0] p_q;
	logic [5:0]         cnt_q;
	logic [63:0]        dv_q;
	logic [4:0]         rem_q;
	logic [2:0]         dcnt_q;
	logic [47:0]        e_q;
	logic [47:0]        weh_q;
	logic [47:0]        wel_q;
	logic [47:0]        wy_q;
	logic [63:0]        contrib_q;

	// accumulator store
	logic [63:0]           num_mem [MAX_LEAVES];
	logic [63:0]           den_mem [MAX_LEAVES];
	logic [MAX_LEAVES-1:0] valid_q;
	logic [63:0]           rd_num_q;
	logic [63:0]           rd_den_q;
	logic                  rd_vld_q;
	logic [3:0]            rd_addr;
	logic                  acc_we;

	// emission datapath
	logic [4:0]         i_q;
	logic [63:0]        den_q;
	logic [63:0]        lv_q;
	logic [5:0]         le_q;
	logic [39:0]        frac_q;
	logic               lsel_q;
	logic [45:0]        ln_q;
	logic [45:0]        ld_q;
	logic               rneg_q;
	logic signed [21:0] pred_q;
	logic               empty_q;

	// result register
	logic               res_valid_q;
	logic [3:0]         res_id_q;
	logic signed [21:0] res_pred_q;
	logic               res_empty_q;
	logic               res_last_q;

	// multiplier handshake
	logic        mul_start_q;
	logic        mul_wait_q;
	logic [63:0] mul_a_q;
	logic [63:0] mul_b_q;
	logic        mul_done;
	logic [63:0] mul_p;

	// combinational helpers
	logic [63:0]        dv_n;
	logic [4:0]         rem_n;
	logic [63:0]        s_new;
	logic signed [12:0] sh;
	logic [47:0]        e_n;
	logic [63:0]        num_old;
	logic [63:0]        den_old;
	logic [64:0]        num_add;
	logic [64:0]        den_add;
	logic [63:0]        num_sum;
	logic [63:0]        den_sum;
	logic [63:0]        sq_m;
	logic               sq_hi;
	logic [39:0]        frac_n;
	logic [45:0]        lcur;
	logic [63:0]        mag;
	logic signed [21:0] ratio;
	logic [4:0]         n_use;
	logic               later;
	logic               out_free;
	logic [20:0]        xmag;

	plvf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	// eight restoring steps of the small divider per cycle
	always_comb begin
		logic [5:0] r6;
		dv_n  = dv_q;
		rem_n = rem_q;
		for (int j = 0; j < 8; j++) begin
			r6   = {rem_n, dv_n[63]};
			dv_n = {dv_n[62:0], 1'b0};
			if (r6 >= {1'b0, k_q}) begin
				r6      = r6 - {1'b0, k_q};
				dv_n[0] = 1'b1;
			end
			rem_n = r6[4:0];
		end
		s_new = (neg_q && k_q[0]) ? s_q - dv_n : s_q + dv_n;
	end

	// final scaling of the squared mantissa into Q24.24, round half up
	always_comb begin
		sh = 13'sd38 - {p_q[11], p_q};
		if (sh <= 13'sd0)
			e_n = '1;
		else if (sh >= 13'sd64)
			e_n = '0;
		else
			e_n = 48'(m_q >> sh[5:0]) + 48'(m_q[sh[5:0] - 6'd1]);
	end

	always_comb begin
		num_old = rd_vld_q ? rd_num_q : '0;
		den_old = rd_vld_q ? rd_den_q : '0;
		num_add = {1'b0, num_old} + {17'd0, wy_q};
		den_add = {1'b0, den_old} + {1'b0, contrib_q};
		num_sum = num_add[64] ? '1 : num_add[63:0];
		den_sum = den_add[64] ? '1 : den_add[63:0];
	end

	always_comb begin
		sq_hi  = mul_p[63];
		sq_m   = sq_hi ? {1'b0, mul_p[63:1]} : mul_p;
		frac_n = {frac_q[38:0], sq_hi};
		lcur   = {le_q, frac_n};
		mag    = (mul_p + 64'h80_0000) >> 24;
		if (!rneg_q)
			ratio = (mag > 64'd2097151) ? PRED_MAX : 22'(mag);
		else
			ratio = (mag > 64'd2097152) ? PRED_MIN : -22'(mag);
	end

	// is there a present leaf in use above the current one
	always_comb begin
		n_use = leaves_in_use(cfg);
		later = 1'b0;
		for (int j = 0; j < 16; j++)
			if ((5'(j) < n_use) && cfg.present_mask[j] && (5'(j) > i_q))
				later = 1'b1;
	end

	assign xmag     = item_q.x[20] ? 21'(-item_q.x) : 21'(item_q.x);
	assign out_free = !res_valid_q || res.ready;
	assign pop      = (state_q == S_IDLE) && !empty;
	assign acc_we   = (state_q == S_RMW);
	assign rd_addr  = ((state_q == S_EMIT_RD) || (state_q == S_EMIT_CHECK)) ? i_q[3:0]
		: item_q.leaf;

	always_ff @(posedge clk) begin
		if (acc_we) begin
			num_mem[item_q.leaf] <= num_sum;
			den_mem[item_q.leaf] <= den_sum;
		end
		rd_num_q <= num_mem[rd_addr];
		rd_den_q <= den_mem[rd_addr];
		rd_vld_q <= valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			mul_wait_q  <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			// S_OUT reloads the result register itself
			if (res.valid && res.ready && (state_q != S_OUT))
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						item_q <= head;
						if (head.acc) begin
							state_q <= S_EXP_INIT;
						end else if (head.last) begin
							i_q     <= 5'd0;
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_EXP_INIT: begin
					neg_q   <= item_q.x[20];
					a_q     <= {2'b00, xmag, 41'd0};
					t_q     <= ONE_Q62;
					s_q     <= ONE_Q62;
					k_q     <= 5'd1;
					state_q <= S_TERM_MUL;
				end
				S_TERM_MUL: begin
					if (!mul_wait_q) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= t_q;
						mul_b_q     <= a_q;
						mul_wait_q  <= 1'b1;
					end else if (mul_done) begin
						mul_wait_q <= 1'b0;
						dv_q       <= mul_p;
						rem_q      <= 5'd0;
						dcnt_q     <= 3'd0;
						state_q    <= S_TERM_DIV;
					end
				end
				S_TERM_DIV: begin
					dv_q   <= dv_n;
					rem_q  <= rem_n;
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						t_q <= dv_n;
						s_q <= s_new;
						if (k_q == TAYLOR_TERMS) begin
							m_q     <= s_new;
							p_q     <= '0;
							state_q <= S_NORM;
						end else begin
							k_q     <= k_q + 5'd1;
							state_q <= S_TERM_MUL;
						end
					end
				end
				S_NORM: begin
					if ((m_q != '0) && (m_q[63:62] == 2'b00)) begin
						m_q <= {m_q[62:0], 1'b0};
						p_q <= p_q - 12'sd1;
					end else begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (!mul_wait_q) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= m_q;
						mul_b_q     <= m_q;
						mul_wait_q  <= 1'b1;
					end else if (mul_done) begin
						mul_wait_q <= 1'b0;
						m_q        <= sq_m;
						p_q        <= {p_q[10:0], sq_hi};
						cnt_q      <= cnt_q + 6'd1;
						if (cnt_q == EXP_SQUARINGS - 6'd1)
							state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					e_q     <= e_n;
					state_q <= S_WEH;
				end
				S_WEH: begin
					weh_q   <= item_q.obs_weight * e_q[47:24];
					state_q <= S_WEL;
				end
				S_WEL: begin
					wel_q   <= item_q.obs_weight * e_q[23:0];
					state_q <= S_WY;
				end
				S_WY: begin
					wy_q    <= item_q.obs_weight * item_q.count_value;
					state_q <= S_CONTRIB;
				end
				S_CONTRIB: begin
					contrib_q <= {8'd0, weh_q, 8'd0} + 64'(({1'b0, wel_q} + 49'h8000) >> 16);
					state_q   <= S_RMW;
				end
				S_RMW: begin
					valid_q[item_q.leaf] <= 1'b1;
					if (item_q.last) begin
						i_q     <= 5'd0;
						state_q <= S_EMIT_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_RD: begin
					if (i_q >= n_use) begin
						valid_q <= '0;
						state_q <= S_IDLE;
					end else if (!cfg.present_mask[i_q[3:0]]) begin
						i_q <= i_q + 5'd1;
					end else begin
						state_q <= S_EMIT_CHECK;
					end
				end
				S_EMIT_CHECK: begin
					den_q <= den_old;
					if (den_old == '0) begin
						pred_q  <= '0;
						empty_q <= 1'b1;
						state_q <= S_OUT;
					end else if (num_old == '0) begin
						pred_q  <= PRED_MIN;
						empty_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						lv_q    <= num_old;
						le_q    <= 6'd63;
						lsel_q  <= 1'b0;
						state_q <= S_LOG_NORM;
					end
				end
				S_LOG_NORM: begin
					if (!lv_q[63]) begin
						lv_q <= {lv_q[62:0], 1'b0};
						le_q <= le_q - 6'd1;
					end else begin
						m_q     <= {1'b0, lv_q[63:1]};
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_LOG_SQ;
					end
				end
				S_LOG_SQ: begin
					if (!mul_wait_q) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= m_q;
						mul_b_q     <= m_q;
						mul_wait_q  <= 1'b1;
					end else if (mul_done) begin
						mul_wait_q <= 1'b0;
						m_q        <= sq_m;
						frac_q     <= frac_n;
						cnt_q      <= cnt_q + 6'd1;
						if (cnt_q == LOG_BITS - 6'd1) begin
							if (!lsel_q) begin
								ln_q    <= lcur;
								lv_q    <= den_q;
								le_q    <= 6'd63;
								lsel_q  <= 1'b1;
								state_q <= S_LOG_NORM;
							end else begin
								ld_q    <= lcur;
								state_q <= S_LN_MUL;
							end
						end
					end
				end
				S_LN_MUL: begin
					if (!mul_wait_q) begin
						mul_start_q <= 1'b1;
						rneg_q      <= (ln_q < ld_q);
						mul_a_q     <= (ln_q < ld_q) ? 64'(ld_q - ln_q) : 64'(ln_q - ld_q);
						mul_b_q     <= LN2_Q62;
						mul_wait_q  <= 1'b1;
					end else if (mul_done) begin
						mul_wait_q <= 1'b0;
						pred_q     <= ratio;
						empty_q    <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_id_q    <= i_q[3:0];
						res_pred_q  <= pred_q;
						res_empty_q <= empty_q;
						res_last_q  <= !later;
						i_q         <= i_q + 5'd1;
						state_q     <= S_EMIT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid      = res_valid_q;
	assign res.leaf_id    = res_id_q;
	assign res.prediction = res_pred_q;
	assign res.empty_leaf = res_empty_q;
	assign res.last_leaf  = res_last_q;

endmodule

// ----- sv/poisson_leaf_value_fit.sv -----
// An observation that is out of bag or in an unused leaf retires without the exponential;
// an accumulated one runs 20 Taylor terms, a normalise, 5 squarings, rounding and weighting
// on the shared four-pass Q.62 multiplier and the 8-bit-per-cycle term divider. Emission
// of each populated leaf runs two 40-step log2 loops on the same multiplier.
// Reset clears the control state and the accumulator valid bits at once.
// ----------------------------------------------------------------------------
// poisson_leaf_value_fit
// Newton leaf-value fit for Poisson regression trees: front end, queue, back end.
// ----------------------------------------------------------------------------
module poisson_leaf_value_fit
	import plvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	plvf_obs_if.sink    obs,
	plvf_res_if.source  res,
	input  logic        cfg_we,
	input  cfg_reg_t    cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t  cfg;
	logic  push;
	work_t push_item;
	logic  full;
	logic  pop;
	logic  empty;
	work_t head;

	plvf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs       (obs),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	plvf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	plvf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

// ----- sv/plvf_checker.sv -----
// ----------------------------------------------------------------------------
// plvf_checker
// Port-level checks on the result channel of the leaf value fit.
// ----------------------------------------------------------------------------
module plvf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [3:0]  leaf_id,
	input logic [21:0] prediction,
	input logic        empty_leaf,
	input logic        last_leaf
);

	logic       run_q;
	logic [3:0] prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			prev_q <= 4'd0;
		end else if (res_valid && res_ready) begin
			run_q  <= !last_leaf;
			prev_q <= leaf_id;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transaction");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_leaf |-> prediction == 22'd0)
		else $error("empty leaf with nonzero prediction");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && run_q |-> leaf_id > prev_q)
		else $error("leaf results out of order");

endmodule

bind poisson_leaf_value_fit plvf_checker u_plvf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.leaf_id    (res.leaf_id),
	.prediction (res.prediction),
	.empty_leaf (res.empty_leaf),
	.last_leaf  (res.last_leaf)
);
